@@ rtl/core/hsv_to_rgb_pixel_macros.svh @@
// Assertion macros shared by the verification files of the HSV to RGB pixel block.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HSV_TO_RGB_PIXEL_MACROS_SVH
`define HSV_TO_RGB_PIXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSVRGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSVRGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hsvrgb_pkg.sv @@
// Shared types and constants for the HSV to RGB pixel pipeline.
// Depends on nothing; every other file of the block but the macro header refers to it by scoped names.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W          = 9;
    localparam int CH_W           = 8;
    localparam int REM_W          = 6;
    localparam int SECTOR_W       = 4;
    localparam int HUE_SECTOR_DEG = 60;
    localparam int FULL_SCALE     = 255;
    localparam int FRAC_SCALE     = FULL_SCALE * HUE_SECTOR_DEG;
    localparam int FRAC_W         = 14;
    localparam int PROD_P_W       = 2 * CH_W;
    localparam int PROD_Q_W       = CH_W + FRAC_W;
    localparam int MAX_SECTOR     = (2 ** HUE_W - 1) / HUE_SECTOR_DEG;
    localparam int PIPE_DEPTH     = 5;

    // Exact floor division by reciprocal multiplication. The shift is the
    // dividend width plus the divisor width, so the rounding error of the
    // multiplier never reaches the next integer.
    localparam int DIV_FULL_SHIFT = PROD_P_W + CH_W;
    localparam int DIV_FULL_MUL_W = 17;
    localparam longint unsigned DIV_FULL_MUL_L =
        ((longint'(1) << DIV_FULL_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
    localparam logic [DIV_FULL_MUL_W-1:0] DIV_FULL_MUL = DIV_FULL_MUL_W'(DIV_FULL_MUL_L);

    localparam int DIV_FRAC_SHIFT = PROD_Q_W + FRAC_W;
    localparam int DIV_FRAC_MUL_W = 23;
    localparam longint unsigned DIV_FRAC_MUL_L =
        ((longint'(1) << DIV_FRAC_SHIFT) + FRAC_SCALE - 1) / FRAC_SCALE;
    localparam logic [DIV_FRAC_MUL_W-1:0] DIV_FRAC_MUL = DIV_FRAC_MUL_W'(DIV_FRAC_MUL_L);

    // Hue sectors, each sixty degrees wide.
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 4'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 4'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 4'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 4'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 4'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_RED   = 4'd5;

    // Fields that travel unchanged alongside the arithmetic.
    typedef struct packed {
        logic                grey;
        logic [SECTOR_W-1:0] sector;
        logic [CH_W-1:0]     val;
        logic [CH_W-1:0]     alpha;
    } ctx_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  sat;
    } sect_t;

    typedef struct packed {
        ctx_t            ctx;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] t;
    } lvl_t;

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } load_t;

endpackage

@@ rtl/core/hsvrgb_sector.sv @@
// First pipeline stage: splits the hue into sector and remainder and registers it.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_sector
(
    input  logic                              clk,
    input  hsvrgb_pkg::load_t                 load,
    input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]       saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]       brightness,
    input  logic [hsvrgb_pkg::CH_W-1:0]       opacity_in,
    output hsvrgb_pkg::sect_t                 sect
);

    hsvrgb_pkg::sect_t                    sect_next;
    hsvrgb_pkg::sect_t                    sect_reg;
    logic [hsvrgb_pkg::SECTOR_W-1:0]      sector;
    logic [hsvrgb_pkg::HUE_W-1:0]         base;

    // Eight independent threshold compares; the last one passed gives the sector.
    always_comb
    begin
        sector = '0;
        base   = '0;
        for (int k = 1; k <= hsvrgb_pkg::MAX_SECTOR; k++)
        begin
            if (hue >= hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::HUE_SECTOR_DEG))
            begin
                sector = hsvrgb_pkg::SECTOR_W'(k);
                base   = hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::HUE_SECTOR_DEG);
            end
        end
    end

    always_comb
    begin
        sect_next.ctx.grey   = (saturation == '0);
        sect_next.ctx.sector = sector;
        sect_next.ctx.val    = brightness;
        sect_next.ctx.alpha  = opacity_in;
        sect_next.rem        = hsvrgb_pkg::REM_W'(hue - base);
        sect_next.sat        = saturation;
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            sect_reg <= sect_next;
        end
    end

    assign sect = sect_reg;

endmodule

@@ rtl/core/hsvrgb_levels.sv @@
// Stages two to four: forms the p, q and t levels with exact floor division.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_levels
(
    input  logic               clk,
    input  hsvrgb_pkg::load_t  load,
    input  hsvrgb_pkg::sect_t  sect,
    output hsvrgb_pkg::lvl_t   lvl
);

    localparam int P_MUL_W = hsvrgb_pkg::PROD_P_W + hsvrgb_pkg::DIV_FULL_MUL_W;
    localparam int Q_MUL_W = hsvrgb_pkg::PROD_Q_W + hsvrgb_pkg::DIV_FRAC_MUL_W;

    // Stage two: numerators of the three levels.
    hsvrgb_pkg::ctx_t                      ctx2_reg;
    logic [hsvrgb_pkg::CH_W-1:0]           np_reg;
    logic [hsvrgb_pkg::FRAC_W-1:0]         nq_reg;
    logic [hsvrgb_pkg::FRAC_W-1:0]         nt_reg;
    logic [hsvrgb_pkg::FRAC_W-1:0]         sr_q;
    logic [hsvrgb_pkg::FRAC_W-1:0]         sr_t;
    logic [hsvrgb_pkg::CH_W-1:0]           np_next;
    logic [hsvrgb_pkg::FRAC_W-1:0]         nq_next;
    logic [hsvrgb_pkg::FRAC_W-1:0]         nt_next;

    // Stage three: products with the brightness.
    hsvrgb_pkg::ctx_t                      ctx3_reg;
    logic [hsvrgb_pkg::PROD_P_W-1:0]       pp_reg;
    logic [hsvrgb_pkg::PROD_Q_W-1:0]       pq_reg;
    logic [hsvrgb_pkg::PROD_Q_W-1:0]       pt_reg;
    logic [hsvrgb_pkg::PROD_P_W-1:0]       pp_next;
    logic [hsvrgb_pkg::PROD_Q_W-1:0]       pq_next;
    logic [hsvrgb_pkg::PROD_Q_W-1:0]       pt_next;

    // Stage four: reciprocal multiplications.
    hsvrgb_pkg::lvl_t                      lvl_reg;
    hsvrgb_pkg::lvl_t                      lvl_next;
    logic [P_MUL_W-1:0]                    p_prod;
    logic [Q_MUL_W-1:0]                    q_prod;
    logic [Q_MUL_W-1:0]                    t_prod;

    always_comb
    begin
        sr_q    = hsvrgb_pkg::FRAC_W'(sect.sat) * hsvrgb_pkg::FRAC_W'(sect.rem);
        sr_t    = hsvrgb_pkg::FRAC_W'(sect.sat)
                * hsvrgb_pkg::FRAC_W'(hsvrgb_pkg::REM_W'(hsvrgb_pkg::HUE_SECTOR_DEG) - sect.rem);
        np_next = hsvrgb_pkg::CH_W'(hsvrgb_pkg::FULL_SCALE) - sect.sat;
        nq_next = hsvrgb_pkg::FRAC_W'(hsvrgb_pkg::FRAC_SCALE) - sr_q;
        nt_next = hsvrgb_pkg::FRAC_W'(hsvrgb_pkg::FRAC_SCALE) - sr_t;
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            ctx2_reg <= sect.ctx;
            np_reg   <= np_next;
            nq_reg   <= nq_next;
            nt_reg   <= nt_next;
        end
    end

    always_comb
    begin
        pp_next = hsvrgb_pkg::PROD_P_W'(ctx2_reg.val) * hsvrgb_pkg::PROD_P_W'(np_reg);
        pq_next = hsvrgb_pkg::PROD_Q_W'(ctx2_reg.val) * hsvrgb_pkg::PROD_Q_W'(nq_reg);
        pt_next = hsvrgb_pkg::PROD_Q_W'(ctx2_reg.val) * hsvrgb_pkg::PROD_Q_W'(nt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            ctx3_reg <= ctx2_reg;
            pp_reg   <= pp_next;
            pq_reg   <= pq_next;
            pt_reg   <= pt_next;
        end
    end

    // Every quotient lies in 0..255, so eight bits above the shift hold it exactly.
    always_comb
    begin
        p_prod       = P_MUL_W'(pp_reg) * P_MUL_W'(hsvrgb_pkg::DIV_FULL_MUL);
        q_prod       = Q_MUL_W'(pq_reg) * Q_MUL_W'(hsvrgb_pkg::DIV_FRAC_MUL);
        t_prod       = Q_MUL_W'(pt_reg) * Q_MUL_W'(hsvrgb_pkg::DIV_FRAC_MUL);
        lvl_next.ctx = ctx3_reg;
        lvl_next.p   = p_prod[hsvrgb_pkg::DIV_FULL_SHIFT +: hsvrgb_pkg::CH_W];
        lvl_next.q   = q_prod[hsvrgb_pkg::DIV_FRAC_SHIFT +: hsvrgb_pkg::CH_W];
        lvl_next.t   = t_prod[hsvrgb_pkg::DIV_FRAC_SHIFT +: hsvrgb_pkg::CH_W];
    end

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            lvl_reg <= lvl_next;
        end
    end

    assign lvl = lvl_reg;

endmodule

@@ rtl/core/hsvrgb_select.sv @@
// Final stage: routes the levels to the color channels by sector into the output register.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_select
(
    input  logic                         clk,
    input  hsvrgb_pkg::load_t            load,
    input  hsvrgb_pkg::lvl_t             lvl,
    output logic [hsvrgb_pkg::CH_W-1:0]  red,
    output logic [hsvrgb_pkg::CH_W-1:0]  green,
    output logic [hsvrgb_pkg::CH_W-1:0]  blue,
    output logic [hsvrgb_pkg::CH_W-1:0]  opacity_out
);

    logic [hsvrgb_pkg::CH_W-1:0] red_next;
    logic [hsvrgb_pkg::CH_W-1:0] green_next;
    logic [hsvrgb_pkg::CH_W-1:0] blue_next;
    logic [hsvrgb_pkg::CH_W-1:0] red_reg;
    logic [hsvrgb_pkg::CH_W-1:0] green_reg;
    logic [hsvrgb_pkg::CH_W-1:0] blue_reg;
    logic [hsvrgb_pkg::CH_W-1:0] alpha_reg;

    always_comb
    begin
        if (lvl.ctx.grey)
        begin
            red_next   = lvl.ctx.val;
            green_next = lvl.ctx.val;
            blue_next  = lvl.ctx.val;
        end
        else
        begin
            case (lvl.ctx.sector)
                hsvrgb_pkg::SECTOR_RED_YELLOW:
                begin
                    red_next = lvl.ctx.val; green_next = lvl.t;       blue_next = lvl.p;
                end
                hsvrgb_pkg::SECTOR_YELLOW_GREEN:
                begin
                    red_next = lvl.q;       green_next = lvl.ctx.val; blue_next = lvl.p;
                end
                hsvrgb_pkg::SECTOR_GREEN_CYAN:
                begin
                    red_next = lvl.p;       green_next = lvl.ctx.val; blue_next = lvl.t;
                end
                hsvrgb_pkg::SECTOR_CYAN_BLUE:
                begin
                    red_next = lvl.p;       green_next = lvl.q;       blue_next = lvl.ctx.val;
                end
                hsvrgb_pkg::SECTOR_BLUE_MAGENTA:
                begin
                    red_next = lvl.t;       green_next = lvl.p;       blue_next = lvl.ctx.val;
                end
                hsvrgb_pkg::SECTOR_MAGENTA_RED:
                begin
                    red_next = lvl.ctx.val; green_next = lvl.p;       blue_next = lvl.q;
                end
                // A hue of 360 degrees or more gives black.
                default:
                begin
                    red_next = '0;          green_next = '0;          blue_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= lvl.ctx.alpha;
        end
    end

    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign opacity_out = alpha_reg;

endmodule

@@ rtl/core/hsv_to_rgb_pixel.sv @@
// HSV to RGB pixel converter: top level with the pipeline valid and stall control.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_levels and hsvrgb_select.
`timescale 1ns / 1ps

// Converts one HSV pixel with alpha into RGBA per request.
// Input channel: in_valid / in_stall with hue (degrees), saturation, brightness, opacity_in.
// Output channel: out_valid / out_stall with red, green, blue, opacity_out.
// A request is taken at a rising edge where valid is high and stall is low.
// The datapath is five register stages: sector split, numerators, brightness
// products, reciprocal division and channel selection into the output register.
// A request moves through these registers in that order; throughput is one pixel
// per cycle as long as the receiver does not hold out_stall.
// Each stage carries a valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up and a request is accepted while a finished result
// still waits at the output.
// When the receiver holds out_stall, the output register keeps its result and the
// stages behind it fill; in_stall rises only when all five stages hold a pixel.
// Reset clears all valid bits; the pipeline is empty and ready right after reset.

module hsv_to_rgb_pixel
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [hsvrgb_pkg::HUE_W-1:0]     hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]      saturation,
    input  logic [hsvrgb_pkg::CH_W-1:0]      brightness,
    input  logic [hsvrgb_pkg::CH_W-1:0]      opacity_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [hsvrgb_pkg::CH_W-1:0]      red,
    output logic [hsvrgb_pkg::CH_W-1:0]      green,
    output logic [hsvrgb_pkg::CH_W-1:0]      blue,
    output logic [hsvrgb_pkg::CH_W-1:0]      opacity_out
);

    localparam int DEPTH = hsvrgb_pkg::PIPE_DEPTH;

    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [DEPTH-1:0]   ready;
    hsvrgb_pkg::load_t  load;
    hsvrgb_pkg::sect_t  sect;
    hsvrgb_pkg::lvl_t   lvl;

    // A stage can load when it is empty or its content moves on this edge.
    always_comb
    begin
        ready[DEPTH-1] = !valid_reg[DEPTH-1] || !out_stall;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load.s1   = ready[0];
    assign load.s2   = ready[1];
    assign load.s3   = ready[2];
    assign load.s4   = ready[3];
    assign load.s5   = ready[4];
    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[DEPTH-1];

    hsvrgb_sector u_sector
    (
        .clk        (clk),
        .load       (load),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .opacity_in (opacity_in),
        .sect       (sect)
    );

    hsvrgb_levels u_levels
    (
        .clk  (clk),
        .load (load),
        .sect (sect),
        .lvl  (lvl)
    );

    hsvrgb_select u_select
    (
        .clk         (clk),
        .load        (load),
        .lvl         (lvl),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .opacity_out (opacity_out)
    );

endmodule

@@ rtl/core/hsvrgb_monitor.sv @@
// Port-level checks for the HSV to RGB pixel converter, bound to its top level.
// Depends on hsvrgb_pkg and hsv_to_rgb_pixel_macros.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb_pixel_macros.svh"

module hsvrgb_monitor
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [hsvrgb_pkg::CH_W-1:0]      red,
    input  logic [hsvrgb_pkg::CH_W-1:0]      green,
    input  logic [hsvrgb_pkg::CH_W-1:0]      blue,
    input  logic [hsvrgb_pkg::CH_W-1:0]      opacity_out
);

    localparam int OCC_W = $clog2(hsvrgb_pkg::PIPE_DEPTH + 1);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_take;
    logic             out_take;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // Number of requests taken in but not yet delivered.
    always_comb
    begin
        occ_next = occ_reg;
        if (in_take && !out_take)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (out_take && !in_take)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `HSVRGB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(opacity_out), "stalled result changed or vanished")
    `HSVRGB_ASSERT_NOW(a_ready_when_empty, !out_valid, !in_stall, "input stalled while the output register is empty")
    `HSVRGB_ASSERT_NOW(a_out_has_source, out_valid, occ_reg != '0, "result offered with no request in flight")
    `HSVRGB_ASSERT_NOW(a_occ_bound, in_stall, occ_reg == OCC_W'(hsvrgb_pkg::PIPE_DEPTH), "input stalled before the pipeline is full")

endmodule

bind hsv_to_rgb_pixel hsvrgb_monitor u_monitor (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the HSV to RGB pixel converter, top module tb.
// Depends on hsvrgb_pkg and hsv_to_rgb_pixel; it predicts RGBA with exact integer floors.
`timescale 1ns / 1ps

class rgba_checker;

    typedef struct packed {
        logic [hsvrgb_pkg::CH_W-1:0] red;
        logic [hsvrgb_pkg::CH_W-1:0] green;
        logic [hsvrgb_pkg::CH_W-1:0] blue;
        logic [hsvrgb_pkg::CH_W-1:0] alpha;
    } rgba_t;

    rgba_t       pending_rgba[$];
    int unsigned mismatches;
    int unsigned converted;
    int unsigned grey_seen;
    int unsigned black_seen;

    function rgba_t hsv_to_rgba(logic [hsvrgb_pkg::HUE_W-1:0] h,
                                logic [hsvrgb_pkg::CH_W-1:0] s,
                                logic [hsvrgb_pkg::CH_W-1:0] v,
                                logic [hsvrgb_pkg::CH_W-1:0] a);
        logic [hsvrgb_pkg::SECTOR_W-1:0] sector;
        int unsigned rem;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        rgba_t px;
        sector = hsvrgb_pkg::SECTOR_W'(h / hsvrgb_pkg::HUE_SECTOR_DEG);
        rem = h % hsvrgb_pkg::HUE_SECTOR_DEG;
        p = (v * (hsvrgb_pkg::FULL_SCALE - s)) / hsvrgb_pkg::FULL_SCALE;
        q = (v * (hsvrgb_pkg::FRAC_SCALE - s * rem)) / hsvrgb_pkg::FRAC_SCALE;
        t = (v * (hsvrgb_pkg::FRAC_SCALE - s * (hsvrgb_pkg::HUE_SECTOR_DEG - rem)))
            / hsvrgb_pkg::FRAC_SCALE;
        px.alpha = a;
        if (s == '0)
        begin
            px.red   = v;
            px.green = v;
            px.blue  = v;
        end
        else
        begin
            case (sector)
                hsvrgb_pkg::SECTOR_RED_YELLOW:   px[31:8] = {v, 8'(t), 8'(p)};
                hsvrgb_pkg::SECTOR_YELLOW_GREEN: px[31:8] = {8'(q), v, 8'(p)};
                hsvrgb_pkg::SECTOR_GREEN_CYAN:   px[31:8] = {8'(p), v, 8'(t)};
                hsvrgb_pkg::SECTOR_CYAN_BLUE:    px[31:8] = {8'(p), 8'(q), v};
                hsvrgb_pkg::SECTOR_BLUE_MAGENTA: px[31:8] = {8'(t), 8'(p), v};
                hsvrgb_pkg::SECTOR_MAGENTA_RED:  px[31:8] = {v, 8'(p), 8'(q)};
                default:                         px[31:8] = '0;
            endcase
        end
        return px;
    endfunction

    function void note_request(logic [hsvrgb_pkg::HUE_W-1:0] h,
                               logic [hsvrgb_pkg::CH_W-1:0] s,
                               logic [hsvrgb_pkg::CH_W-1:0] v,
                               logic [hsvrgb_pkg::CH_W-1:0] a);
        if (s == '0)
            grey_seen++;
        else if (h >= 6 * hsvrgb_pkg::HUE_SECTOR_DEG)
            black_seen++;
        pending_rgba.push_back(hsv_to_rgba(h, s, v, a));
    endfunction

    function void check_result(logic [hsvrgb_pkg::CH_W-1:0] r,
                               logic [hsvrgb_pkg::CH_W-1:0] g,
                               logic [hsvrgb_pkg::CH_W-1:0] b,
                               logic [hsvrgb_pkg::CH_W-1:0] a);
        rgba_t want;
        if (pending_rgba.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result r=%h g=%h b=%h a=%h", $realtime, r, g, b, a);
            return;
        end
        want = pending_rgba.pop_front();
        converted++;
        if (r !== want.red || g !== want.green || b !== want.blue || a !== want.alpha)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                         $realtime, want.red, want.green, want.blue, want.alpha, r, g, b, a);
        end
    endfunction

    function int unsigned pending();
        return pending_rgba.size();
    endfunction

endclass

module tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic [hsvrgb_pkg::HUE_W-1:0] hue = '0;
    logic [hsvrgb_pkg::CH_W-1:0]  saturation = '0;
    logic [hsvrgb_pkg::CH_W-1:0]  brightness = '0;
    logic [hsvrgb_pkg::CH_W-1:0]  opacity_in = '0;
    logic in_stall;
    logic out_valid;
    logic [hsvrgb_pkg::CH_W-1:0] red;
    logic [hsvrgb_pkg::CH_W-1:0] green;
    logic [hsvrgb_pkg::CH_W-1:0] blue;
    logic [hsvrgb_pkg::CH_W-1:0] opacity_out;

    rgba_checker board = new();
    int unsigned cycle_count = 0;
    bit          sender_gaps = 1'b1;

    hsv_to_rgb_pixel dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness),
        .opacity_in  (opacity_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .opacity_out (opacity_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long pause.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_request(hue, saturation, brightness, opacity_in);
            if (out_valid && !out_stall)
                board.check_result(red, green, blue, opacity_out);
        end
    end

    // The receiver switches between calm stretches and bursts of stalls.
    initial
    begin : receiver
        int unsigned hold;
        int unsigned mode;
        int unsigned mode_left;
        hold = 0;
        mode = 0;
        mode_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            else
                mode_left--;
            if (hold != 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (mode != 0 && $urandom_range(0, 99) < 20 * mode)
            begin
                hold = idle_length();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_pixel(input logic [hsvrgb_pkg::HUE_W-1:0] h,
                              input logic [hsvrgb_pkg::CH_W-1:0] s,
                              input logic [hsvrgb_pkg::CH_W-1:0] v,
                              input logic [hsvrgb_pkg::CH_W-1:0] a);
        int unsigned gap;
        gap = sender_gaps ? idle_length() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        opacity_in <= a;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds the sender off until the pipeline has handed back every request.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        @(posedge clk);
    endtask

    initial
    begin : sender
        logic [hsvrgb_pkg::HUE_W-1:0] h;
        logic [hsvrgb_pkg::CH_W-1:0]  s;
        logic [hsvrgb_pkg::CH_W-1:0]  v;
        int unsigned roll;
        int unsigned odd_hues;
        odd_hues = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sector edges, full and minimal levels, grey and out-of-range hues.
        send_pixel(9'd0,   8'd255, 8'd255, 8'd255);
        send_pixel(9'd59,  8'd255, 8'd255, 8'd0);
        send_pixel(9'd60,  8'd255, 8'd255, 8'd170);
        send_pixel(9'd119, 8'd255, 8'd200, 8'd85);
        send_pixel(9'd120, 8'd255, 8'd255, 8'd255);
        send_pixel(9'd179, 8'd128, 8'd255, 8'd1);
        send_pixel(9'd180, 8'd255, 8'd255, 8'd254);
        send_pixel(9'd239, 8'd1,   8'd255, 8'd128);
        send_pixel(9'd240, 8'd255, 8'd255, 8'd255);
        send_pixel(9'd299, 8'd255, 8'd77,  8'd0);
        send_pixel(9'd300, 8'd255, 8'd255, 8'd255);
        send_pixel(9'd359, 8'd255, 8'd255, 8'd128);
        send_pixel(9'd360, 8'd255, 8'd255, 8'd255);
        send_pixel(9'd511, 8'd255, 8'd255, 8'd0);
        send_pixel(9'd400, 8'd0,   8'd200, 8'd33);
        send_pixel(9'd511, 8'd0,   8'd255, 8'd255);
        send_pixel(9'd0,   8'd0,   8'd0,   8'd0);
        send_pixel(9'd200, 8'd255, 8'd0,   8'd255);
        send_pixel(9'd30,  8'd1,   8'd1,   8'd7);
        send_pixel(9'd90,  8'd100, 8'd3,   8'd3);
        send_pixel(9'd210, 8'd254, 8'd254, 8'd254);
        drain_pipeline();

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                sender_gaps = ($urandom_range(0, 2) != 0);
            if (i == 450 || i == 900)
                drain_pipeline();
            roll = $urandom_range(0, 99);
            if (roll < 80)
                h = hsvrgb_pkg::HUE_W'($urandom_range(0, 359));
            else if (roll < 90)
                h = hsvrgb_pkg::HUE_W'(60 * $urandom_range(1, 6) + $urandom_range(0, 2) - 1);
            else
                h = hsvrgb_pkg::HUE_W'($urandom_range(360, 511));
            if (h >= 360)
                odd_hues++;
            roll = $urandom_range(0, 99);
            s = (roll < 10) ? 8'd0 : (roll < 20) ? 8'd255 : (roll < 25) ? 8'd1
                : 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            v = (roll < 8) ? 8'd0 : (roll < 18) ? 8'd255 : 8'($urandom_range(0, 255));
            send_pixel(h, s, v, 8'($urandom_range(0, 255)));
        end
        in_valid <= 1'b0;

        // Step past the last accepting edge so its request is counted first.
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (hsvrgb_pkg::PIPE_DEPTH + 5) @(posedge clk);

        $display("Checked %0d pixels: %0d grey, %0d black from nonzero saturation,",
                 board.converted, board.grey_seen, board.black_seen);
        $display("%0d random hues of 360 or more, with random sender gaps and receiver stalls.",
                 odd_hues);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
